@@ hw/rtl/sitda_pkg.sv @@
package sitda_pkg;

	localparam logic [5:0] CHAR_ZERO  = 6'd48;
	localparam logic [5:0] CHAR_NINE  = 6'd57;
	localparam logic [5:0] CHAR_MINUS = 6'd45;

	// shift-and-add-3 correction for one BCD digit
	localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [3:0] BCD_ADJ     = 4'd3;

	typedef enum logic [1:0] {
		CONV_IDLE,
		CONV_SHIFT,
		CONV_DONE
	} conv_state_t;

endpackage

@@ hw/rtl/signed_int_to_decimal_ascii.sv @@
// Prints a signed VALUE_WIDTH-bit integer as decimal ASCII, one character per output item,
// most significant first, with a leading '-' for negative values and last_char on the final
// character; zero prints as "0". Each number goes through a one-bit-per-cycle shift-and-add-3
// BCD converter. Character output for one number overlaps conversion of the next. An input
// register and a two-entry queue in front of the converter let the input side keep accepting
// while the converter is busy.
module signed_int_to_decimal_ascii #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [5:0]             char_code,
	output logic                   last_char
);

	// decimal digits of a VALUE_WIDTH-bit magnitude (1233/4096 ~ log10(2))
	localparam int NUM_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
	localparam int QW         = VALUE_WIDTH + 1;

	logic                    fr_valid;
	logic                    fr_ready;
	logic                    fr_neg;
	logic [VALUE_WIDTH-1:0]  fr_mag;
	logic                    q_valid;
	logic                    q_ready;
	logic [QW-1:0]           q_data;
	logic                    cv_valid;
	logic                    cv_ready;
	logic                    cv_neg;
	logic [4*NUM_DIGITS-1:0] cv_bcd;

	sitda_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.out_valid(fr_valid),
		.out_ready(fr_ready),
		.out_neg  (fr_neg),
		.out_mag  (fr_mag)
	);

	sitda_fifo #(
		.DATA_WIDTH(QW)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fr_valid),
		.in_ready (fr_ready),
		.in_data  ({fr_neg, fr_mag}),
		.out_valid(q_valid),
		.out_ready(q_ready),
		.out_data (q_data)
	);

	sitda_conv #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.NUM_DIGITS (NUM_DIGITS)
	) u_conv (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_ready (q_ready),
		.in_neg   (q_data[QW-1]),
		.in_mag   (q_data[VALUE_WIDTH-1:0]),
		.out_valid(cv_valid),
		.out_ready(cv_ready),
		.out_neg  (cv_neg),
		.out_bcd  (cv_bcd)
	);

	sitda_emit #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cv_valid),
		.in_ready (cv_ready),
		.in_neg   (cv_neg),
		.in_bcd   (cv_bcd),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.char_code(char_code),
		.last_char(last_char)
	);

endmodule

@@ hw/rtl/sitda_front.sv @@
module sitda_front #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   out_neg,
	output logic [VALUE_WIDTH-1:0] out_mag
);

	logic                   valid_s1;
	logic                   neg_s1;
	logic [VALUE_WIDTH-1:0] mag_s1;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_neg   = neg_s1;
	assign out_mag   = mag_s1;

	// magnitude fits in VALUE_WIDTH unsigned bits, most negative value included
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			neg_s1   <= 1'b0;
			mag_s1   <= '0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			if (in_valid) begin
				neg_s1 <= value[VALUE_WIDTH-1];
				mag_s1 <= value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
			end
		end
	end

endmodule

@@ hw/rtl/sitda_fifo.sv @@
module sitda_fifo #(
	parameter int DATA_WIDTH = 33
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_WIDTH-1:0] in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] out_data
);

	logic [DATA_WIDTH-1:0] mem_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            count_q;
	logic                  push;
	logic                  pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

@@ hw/rtl/sitda_conv.sv @@
module sitda_conv #(
	parameter int VALUE_WIDTH = 32,
	parameter int NUM_DIGITS  = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      in_neg,
	input  logic [VALUE_WIDTH-1:0]    in_mag,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      out_neg,
	output logic [4*NUM_DIGITS-1:0]   out_bcd
);

	localparam int CW = $clog2(VALUE_WIDTH + 1);

	sitda_pkg::conv_state_t state_q;
	sitda_pkg::conv_state_t state_d;

	logic [VALUE_WIDTH-1:0]  mag_q;
	logic [4*NUM_DIGITS-1:0] bcd_q;
	logic [4*NUM_DIGITS-1:0] bcd_adj;
	logic [CW-1:0]           cnt_q;
	logic                    neg_q;

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= sitda_pkg::BCD_ADJ_MIN) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + sitda_pkg::BCD_ADJ;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sitda_pkg::CONV_IDLE: begin
				if (in_valid) state_d = sitda_pkg::CONV_SHIFT;
			end
			sitda_pkg::CONV_SHIFT: begin
				if (cnt_q == CW'(1)) state_d = sitda_pkg::CONV_DONE;
			end
			sitda_pkg::CONV_DONE: begin
				if (out_ready) state_d = sitda_pkg::CONV_IDLE;
			end
			default: state_d = sitda_pkg::CONV_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			sitda_pkg::CONV_IDLE:  in_ready  = 1'b1;
			sitda_pkg::CONV_SHIFT: in_ready  = 1'b0;
			sitda_pkg::CONV_DONE:  out_valid = 1'b1;
			default: begin
				in_ready  = 1'b0;
				out_valid = 1'b0;
			end
		endcase
	end

	assign out_neg = neg_q;
	assign out_bcd = bcd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sitda_pkg::CONV_IDLE;
			mag_q   <= '0;
			bcd_q   <= '0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				mag_q <= in_mag;
				neg_q <= in_neg;
				bcd_q <= '0;
				cnt_q <= CW'(VALUE_WIDTH);
			end else if (state_q == sitda_pkg::CONV_SHIFT) begin
				// one magnitude bit enters the BCD register per cycle, MSB first
				bcd_q <= {bcd_adj[4*NUM_DIGITS-2:0], mag_q[VALUE_WIDTH-1]};
				mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

@@ hw/rtl/sitda_emit.sv @@
module sitda_emit #(
	parameter int NUM_DIGITS = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    in_neg,
	input  logic [4*NUM_DIGITS-1:0] in_bcd,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [5:0]              char_code,
	output logic                    last_char
);

	localparam int IW = $clog2(NUM_DIGITS);

	logic                    busy_q;
	logic                    neg_q;
	logic [4*NUM_DIGITS-1:0] bcd_q;
	logic [IW-1:0]           idx_q;
	logic [IW-1:0]           msd_idx;
	logic [3:0]              cur_digit;
	logic                    out_valid_q;
	logic [5:0]              char_q;
	logic                    last_q;
	logic                    load;
	logic                    adv;

	// highest nonzero digit; zero keeps index 0 so a single '0' goes out
	always_comb begin
		msd_idx = '0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (in_bcd[4*i +: 4] != 4'd0) msd_idx = IW'(i);
		end
	end

	assign in_ready  = !busy_q;
	assign load      = in_valid && in_ready;
	assign adv       = !out_valid_q || out_ready;
	assign cur_digit = bcd_q[4*idx_q +: 4];

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			neg_q       <= 1'b0;
			bcd_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			char_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				neg_q  <= in_neg;
				bcd_q  <= in_bcd;
				idx_q  <= msd_idx;
			end
			if (adv) begin
				if (busy_q) begin
					out_valid_q <= 1'b1;
					if (neg_q) begin
						char_q <= sitda_pkg::CHAR_MINUS;
						last_q <= 1'b0;
						neg_q  <= 1'b0;
					end else begin
						char_q <= sitda_pkg::CHAR_ZERO + {2'b00, cur_digit};
						last_q <= (idx_q == '0);
						if (idx_q == '0) begin
							busy_q <= 1'b0;
						end else begin
							idx_q <= idx_q - IW'(1);
						end
					end
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	a_load_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q)
		else $error("emitter not busy after taking a number");

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> busy_q)
		else $error("non-final item shown but no characters pending");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && char_q == sitda_pkg::CHAR_MINUS) |-> !last_q)
		else $error("minus sign flagged as final character");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (char_q == sitda_pkg::CHAR_MINUS ||
			(char_q >= sitda_pkg::CHAR_ZERO && char_q <= sitda_pkg::CHAR_NINE)))
		else $error("character code out of range");

endmodule
